/* sv/terminal_text_sanitizer_macros.svh */
// Assertion helpers for the checker file, tts_checker.
`ifndef TERMINAL_TEXT_SANITIZER_MACROS_SVH
`define TERMINAL_TEXT_SANITIZER_MACROS_SVH

// Check that post holds in the same cycle as pre.
`define TTS_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("terminal_text_sanitizer: same-cycle check failed");

// Check that post holds in the cycle after pre.
`define TTS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("terminal_text_sanitizer: next-cycle check failed");

`endif

/* sv/tts_pkg.sv */
package tts_pkg;

    // Result list sizing
    localparam int MAX_RESULTS = 7;
    localparam int CNT_W       = 3;

    // UTF-8 hold buffer sizing
    localparam int HELD_DEPTH  = 3;
    localparam int HELD_CNT_W  = 2;
    localparam int EXP_W       = 3;

    // Byte codes
    localparam logic [7:0] ChTab      = 8'h09;
    localparam logic [7:0] ChNewline  = 8'h0A;
    localparam logic [7:0] ChEsc      = 8'h1B;
    localparam logic [7:0] ChSpace    = 8'h20;
    localparam logic [7:0] ChQuest    = 8'h3F;
    localparam logic [7:0] ChAt       = 8'h40;
    localparam logic [7:0] ChLbracket = 8'h5B;
    localparam logic [7:0] ChTilde    = 8'h7E;
    localparam logic [7:0] ChDel      = 8'h7F;
    localparam logic [7:0] ContMask   = 8'hC0;
    localparam logic [7:0] ContCode   = 8'h80;

    // Escape tracking
    typedef enum logic [2:0] {
        ESC_NORMAL = 3'b001,
        ESC_AFTER  = 3'b010,
        ESC_CSI    = 3'b100
    } esc_mode_t;

    typedef struct packed {
        esc_mode_t             esc;
        logic [HELD_CNT_W-1:0] held_count;
        logic [EXP_W-1:0]      exp_len;
    } dec_state_t;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [CNT_W-1:0]            count;
    } result_list_t;

    // Sequence length announced by a UTF-8 lead byte, zero for a non-lead.
    function automatic logic [EXP_W-1:0] lead_len(input logic [7:0] b);
        logic [EXP_W-1:0] n;
        n = '0;
        if (b[7:5] == 3'b110) begin
            n = EXP_W'(2);
        end
        else if (b[7:4] == 4'hE) begin
            n = EXP_W'(3);
        end
        else if (b[7:3] == 5'h1E) begin
            n = EXP_W'(4);
        end
        return n;
    endfunction

endpackage

/* sv/tts_decode.sv */
module tts_decode
    import tts_pkg::*;
#(
    parameter int TAB_WIDTH = 4
)
(
    input  dec_state_t                  st,
    input  logic [HELD_DEPTH-1:0][7:0]  held,
    input  logic [7:0]                  data_byte,
    input  logic                        end_of_text,
    output dec_state_t                  st_next,
    output logic                        wr_en,
    output logic [HELD_CNT_W-1:0]       wr_idx,
    output result_list_t                list
);

    localparam int SumW = $clog2(HELD_DEPTH + TAB_WIDTH + 1);

    logic                  pre_q;
    logic [HELD_CNT_W-1:0] pre_n;
    logic [7:0]            suf_byte;
    logic [SumW-1:0]       suf_n;
    logic [SumW-1:0]       sum;
    logic                  is_cont;
    logic [EXP_W-1:0]      lead_n;

    // Work out the next state and the result list as a prefix plus a repeated suffix
    always_comb
    begin
        st_next  = st;
        wr_en    = 1'b0;
        wr_idx   = '0;
        pre_q    = 1'b0;
        pre_n    = '0;
        suf_byte = data_byte;
        suf_n    = '0;
        lead_n   = lead_len(data_byte);
        is_cont  = (data_byte & ContMask) == ContCode;

        if (end_of_text)
        begin
            // Flush held bytes as bad and leave any escape
            pre_q              = 1'b1;
            pre_n              = st.held_count;
            st_next.held_count = '0;
            st_next.exp_len    = '0;
            st_next.esc        = ESC_NORMAL;
        end
        else if (st.held_count != '0 && is_cont)
        begin
            if ({1'b0, st.held_count} + EXP_W'(1) >= st.exp_len)
            begin
                // Sequence complete: emit held bytes then this one
                pre_n              = st.held_count;
                suf_n              = SumW'(1);
                st_next.held_count = '0;
                st_next.exp_len    = '0;
            end
            else
            begin
                // Append continuation byte
                wr_en              = 1'b1;
                wr_idx             = st.held_count;
                st_next.held_count = st.held_count + HELD_CNT_W'(1);
            end
        end
        else
        begin
            // Broken sequence: held bytes go out as '?'
            if (st.held_count != '0)
            begin
                pre_q              = 1'b1;
                pre_n              = st.held_count;
                st_next.held_count = '0;
                st_next.exp_len    = '0;
            end

            // Handle the byte afresh
            case (st.esc)
                ESC_AFTER:
                begin
                    st_next.esc = (data_byte == ChLbracket) ? ESC_CSI : ESC_NORMAL;
                end
                ESC_CSI:
                begin
                    if (data_byte inside {[ChAt:ChTilde]})
                    begin
                        st_next.esc = ESC_NORMAL;
                    end
                end
                default:
                begin
                    st_next.esc = ESC_NORMAL;
                    if (data_byte == ChTab)
                    begin
                        suf_byte = ChSpace;
                        suf_n    = SumW'(TAB_WIDTH);
                    end
                    else if (data_byte == ChNewline)
                    begin
                        suf_n = SumW'(1);
                    end
                    else if (data_byte == ChEsc)
                    begin
                        st_next.esc = ESC_AFTER;
                    end
                    else if (data_byte < ChSpace || data_byte == ChDel)
                    begin
                        // drop other control bytes
                    end
                    else if (!data_byte[7])
                    begin
                        suf_n = SumW'(1);
                    end
                    else if (lead_n != '0)
                    begin
                        // Start a new UTF-8 sequence
                        wr_en              = 1'b1;
                        wr_idx             = '0;
                        st_next.held_count = HELD_CNT_W'(1);
                        st_next.exp_len    = lead_n;
                    end
                    else
                    begin
                        suf_byte = ChQuest;
                        suf_n    = SumW'(1);
                    end
                end
            endcase
        end
    end

    // Assemble the list, capped at the result limit
    always_comb
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            list.bytes[k] = suf_byte;
        end
        for (int k = 0; k < HELD_DEPTH; k++)
        begin
            if (HELD_CNT_W'(k) < pre_n)
            begin
                list.bytes[k] = pre_q ? ChQuest : held[k];
            end
        end
        sum        = SumW'(pre_n) + suf_n;
        list.count = (sum > SumW'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : sum[CNT_W-1:0];
    end

endmodule

/* sv/tts_emit.sv */
module tts_emit
    import tts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  result_list_t list,
    input  logic         load,
    output logic         can_load,
    output logic         result_valid,
    input  logic         result_ready,
    output logic [7:0]   out_byte,
    output logic         last
);

    logic [MAX_RESULTS-1:0][7:0] bytes_reg;
    logic [MAX_RESULTS-1:0][7:0] bytes_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            cnt_next;
    logic [CNT_W-1:0]            idx_reg;
    logic [CNT_W-1:0]            idx_next;
    logic                        take;

    // Present the current byte of the list
    assign result_valid = cnt_reg != '0;
    assign out_byte     = bytes_reg[idx_reg];
    assign last         = result_valid && (idx_reg == cnt_reg - CNT_W'(1));
    assign take         = result_valid && result_ready;
    assign can_load     = !result_valid || (take && last);

    // Load a new list or advance through the current one
    always_comb
    begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            bytes_next = list.bytes;
            cnt_next   = list.count;
            idx_next   = '0;
        end
        else if (take)
        begin
            if (last)
            begin
                cnt_next = '0;
                idx_next = '0;
            end
            else
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

endmodule

/* sv/terminal_text_sanitizer.sv */
// Terminal text cleaner: takes one raw byte per request and delivers the cleaned bytes, one per
// result request, with last set on the final byte that an input caused. A plain text stream
// flows at one byte per clock while result_ready is high; an input that yields n bytes (a tab,
// a completed UTF-8 sequence, a flushed broken sequence), at most seven, holds the output until
// all n are taken, as the output register hands out one byte per taken result. An accepted
// input goes through the input register, then the result list register. Inputs that yield
// nothing (escape sequences, control bytes, held UTF-8 bytes, end of text with nothing held)
// never show on the output.
module terminal_text_sanitizer
    import tts_pkg::*;
#(
    parameter int TAB_WIDTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_text,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] out_byte,
    output logic       last
);

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic [7:0]                 s1_byte_reg;
    logic                       s1_eot_reg;
    dec_state_t                 st_reg;
    dec_state_t                 st_next;
    logic [HELD_DEPTH-1:0][7:0] held_reg;
    logic [HELD_DEPTH-1:0][7:0] held_next;
    logic                       wr_en;
    logic [HELD_CNT_W-1:0]      wr_idx;
    result_list_t               list;
    logic                       can_load;
    logic                       s1_move;
    logic                       in_take;

    // Input register advances when the output stage can take its list
    assign s1_move    = s1_valid_reg && can_load;
    assign item_ready = !s1_valid_reg || can_load;
    assign in_take    = item_valid && item_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= data_byte;
            s1_eot_reg  <= end_of_text;
        end
    end

    tts_decode #(
        .TAB_WIDTH (TAB_WIDTH)
    ) u_decode (
        .st          (st_reg),
        .held        (held_reg),
        .data_byte   (s1_byte_reg),
        .end_of_text (s1_eot_reg),
        .st_next     (st_next),
        .wr_en       (wr_en),
        .wr_idx      (wr_idx),
        .list        (list)
    );

    // Commit decoder state when the item moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{esc: ESC_NORMAL, held_count: '0, exp_len: '0};
        end
        else if (s1_move)
        begin
            st_reg <= st_next;
        end
    end

    // Hold UTF-8 bytes of an unfinished sequence
    always_comb
    begin
        held_next = held_reg;
        for (int k = 0; k < HELD_DEPTH; k++)
        begin
            if (s1_move && wr_en && wr_idx == HELD_CNT_W'(k))
            begin
                held_next[k] = s1_byte_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    tts_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .list         (list),
        .load         (s1_move),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .last         (last)
    );

endmodule

/* sv/tts_checker.sv */
`include "terminal_text_sanitizer_macros.svh"

module tts_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] out_byte,
    input logic       last
);

    // A stalled result holds
    `TTS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(out_byte) && $stable(last))

    // More bytes follow a taken byte that is not the last
    `TTS_ASSERT_NEXT(a_more_follow, result_valid && result_ready && !last, result_valid)

    // Input only stalls behind pending results
    `TTS_ASSERT_NOW(a_stall_cause, !item_ready, result_valid)

    // Results start from an accepted request, through the input and result list registers
    `TTS_ASSERT_NOW(a_result_origin, $rose(result_valid), $past(item_valid && item_ready, 2))

endmodule

bind terminal_text_sanitizer tts_checker u_tts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .last         (last)
);

/* test/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    localparam int TAB_WIDTH   = 4;
    localparam int QUIET_LIMIT = 2000;
    localparam int CALM_TAIL   = 60;
    localparam int TAIL_CYCLES = 20;
    localparam int RANDOM_REQS = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       eot;
    } text_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } clean_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    logic [7:0] data_byte = 8'h00;
    logic       end_of_text = 1'b0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [7:0] out_byte;
    logic       last;

    text_req_t   pending_reqs[$];
    clean_byte_t expected_bytes[$];
    logic [7:0]  step_bytes[$];

    // Cleaner state as seen by the predictor
    esc_mode_t  esc_state = ESC_NORMAL;
    logic [7:0] held_q[3];
    logic [1:0] held_n = 2'd0;
    logic [2:0] seq_len = 3'd0;

    int  n_errors = 0;
    int  send_gap = 0;
    int  ready_stall = 0;
    bit  send_bursts_on = 1'b1;
    bit  take_bursts_on = 1'b1;
    logic calm = 1'b0;
    int  quiet_cycles = 0;

    terminal_text_sanitizer #(
        .TAB_WIDTH (TAB_WIDTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .data_byte    (data_byte),
        .end_of_text  (end_of_text),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .last         (last)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic void add_req(input logic [7:0] b, input logic eot);
        text_req_t r;
        r.data = b;
        r.eot  = eot;
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    // Queue a UTF-8 lead of the given length followed by conts continuation bytes
    function automatic void add_utf8(input int len, input int conts);
        logic [7:0] lead;
        case (len)
            2:       lead = {3'b110, 5'($urandom)};
            3:       lead = {4'b1110, 4'($urandom)};
            default: lead = {5'b11110, 3'($urandom)};
        endcase
        add_req(lead, 1'b0);
        for (int i = 0; i < conts; i++)
        begin
            add_req({2'b10, 6'($urandom)}, 1'b0);
        end
    endfunction

    // Append one cleaned byte, drop anything past the per-request cap
    function automatic void put_clean(input logic [7:0] b);
        if (step_bytes.size() < MAX_RESULTS)
        begin
            step_bytes.insert(step_bytes.size(), b);
        end
    endfunction

    // Turn every held byte into a question mark
    function automatic void flush_held();
        for (int k = 0; k < held_n; k++)
        begin
            put_clean(ChQuest);
        end
        held_n  = 2'd0;
        seq_len = 3'd0;
    endfunction

    // Handle a byte with nothing held
    function automatic void take_fresh(input logic [7:0] b);
        if (esc_state == ESC_AFTER)
        begin
            if (b == ChLbracket)
            begin
                esc_state = ESC_CSI;
            end
            else
            begin
                esc_state = ESC_NORMAL;
            end
        end
        else if (esc_state == ESC_CSI)
        begin
            if (b >= ChAt && b <= ChTilde)
            begin
                esc_state = ESC_NORMAL;
            end
        end
        else
        begin
            esc_state = ESC_NORMAL;
            if (b == ChTab)
            begin
                for (int t = 0; t < TAB_WIDTH; t++)
                begin
                    put_clean(ChSpace);
                end
            end
            else if (b == ChNewline)
            begin
                put_clean(b);
            end
            else if (b == ChEsc)
            begin
                esc_state = ESC_AFTER;
            end
            else if (b < ContCode)
            begin
                // drop other control bytes and delete
                if (b >= ChSpace && b != ChDel)
                begin
                    put_clean(b);
                end
            end
            else
            begin
                casez (b)
                    8'b110?????: seq_len = 3'd2;
                    8'b1110????: seq_len = 3'd3;
                    8'b11110???: seq_len = 3'd4;
                    default:     seq_len = 3'd0;
                endcase
                if (seq_len == 3'd0)
                begin
                    put_clean(ChQuest);
                end
                else
                begin
                    held_q[0] = b;
                    held_n    = 2'd1;
                end
            end
        end
    endfunction

    // Work out the cleaned bytes for one accepted request and queue them
    function automatic void predict_clean(input logic [7:0] b, input logic eot);
        clean_byte_t e;
        step_bytes.delete();
        if (eot)
        begin
            flush_held();
            esc_state = ESC_NORMAL;
        end
        else if (held_n != 2'd0)
        begin
            if ((b & ContMask) == ContCode)
            begin
                if ({1'b0, held_n} + 3'd1 >= seq_len)
                begin
                    for (int k = 0; k < held_n; k++)
                    begin
                        put_clean(held_q[k]);
                    end
                    put_clean(b);
                    held_n  = 2'd0;
                    seq_len = 3'd0;
                end
                else
                begin
                    held_q[held_n] = b;
                    held_n++;
                end
            end
            else
            begin
                flush_held();
                take_fresh(b);
            end
        end
        else
        begin
            take_fresh(b);
        end
        foreach (step_bytes[i])
        begin
            e.data = step_bytes[i];
            e.last = (i == step_bytes.size() - 1);
            expected_bytes.insert(expected_bytes.size(), e);
        end
    endfunction

    // Present requests from the pending queue, with random idle bursts
    always @(posedge clk)
    begin : p_drive
        text_req_t next_req;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                predict_clean(data_byte, end_of_text);
            end
            calm <= (pending_reqs.size() <= CALM_TAIL);
            if ($urandom_range(0, 47) == 0)
            begin
                send_bursts_on = !send_bursts_on;
            end
            if (item_valid && !item_ready)
            begin
                // hold the current request
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0 && !calm && send_bursts_on
                     && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(1, 11) - 1;
                item_valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                next_req = pending_reqs.pop_front();
                item_valid  <= 1'b1;
                data_byte   <= next_req.data;
                end_of_text <= next_req.eot;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Check each delivered byte against the oldest expectation
    always @(posedge clk)
    begin : p_watch
        clean_byte_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected result: out_byte %02h last %0b", out_byte, last);
                    n_errors++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.data, out_byte);
                        n_errors++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, last);
                        n_errors++;
                    end
                end
            end
            if ($urandom_range(0, 47) == 0)
            begin
                take_bursts_on = !take_bursts_on;
            end
            if (ready_stall > 0)
            begin
                ready_stall--;
                result_ready <= 1'b0;
            end
            else if (!calm && take_bursts_on && $urandom_range(0, 5) == 0)
            begin
                ready_stall = $urandom_range(1, 11) - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // End the run when nothing moves on either channel for too long
    always @(posedge clk)
    begin : p_watchdog
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : p_main
        int pick;
        int n;

        // Directed: plain bytes, controls, escapes, UTF-8 and flushes
        add_req(8'h41, 1'b0);
        add_req(8'h7E, 1'b0);
        add_req(8'h00, 1'b0);
        add_req(ChDel, 1'b0);
        add_req(ChTab, 1'b0);
        add_req(ChNewline, 1'b0);
        add_req(ChEsc, 1'b0);
        add_req(8'h78, 1'b0);
        add_req(ChEsc, 1'b0);
        add_req(ChLbracket, 1'b0);
        add_req(8'h31, 1'b0);
        add_req(8'h6D, 1'b0);
        add_req(8'hC3, 1'b0);
        add_req(8'hA9, 1'b0);
        // three held bytes broken by a tab: the most results from one request
        add_req(8'hF0, 1'b0);
        add_req(8'h9F, 1'b0);
        add_req(8'h98, 1'b0);
        add_req(ChTab, 1'b0);
        add_req(ContCode, 1'b0);
        add_req(8'hFF, 1'b0);
        add_req(8'hE2, 1'b0);
        add_req(8'h82, 1'b0);
        add_req(8'hA5, 1'b1);
        add_req(ChEsc, 1'b0);
        add_req(8'h5A, 1'b1);
        add_req(8'hFF, 1'b1);

        // Random: mostly well-formed text with random content, some noise
        n = pending_reqs.size() + RANDOM_REQS;
        while (pending_reqs.size() < n)
        begin
            pick = $urandom_range(0, 19);
            case (pick)
                0, 1, 2, 3, 4, 5:
                begin
                    add_req(8'($urandom_range(ChSpace, ChTilde)), 1'b0);
                end
                6:
                begin
                    add_req(ChTab, 1'b0);
                end
                7:
                begin
                    add_req(ChNewline, 1'b0);
                end
                8, 9:
                begin
                    add_req(ChEsc, 1'b0);
                    add_req(ChLbracket, 1'b0);
                    repeat ($urandom_range(0, 3))
                    begin
                        add_req(8'($urandom_range(8'h20, 8'h3F)), 1'b0);
                    end
                    add_req(8'($urandom_range(ChAt, ChTilde)), 1'b0);
                end
                10:
                begin
                    add_req(ChEsc, 1'b0);
                    add_req(8'($urandom), 1'b0);
                end
                11, 12, 13:
                begin
                    pick = $urandom_range(2, 4);
                    add_utf8(pick, pick - 1);
                end
                14:
                begin
                    pick = $urandom_range(2, 4);
                    add_utf8(pick, $urandom_range(0, pick - 2));
                    add_req(8'($urandom), 1'b0);
                end
                15, 16:
                begin
                    add_req(8'($urandom), 1'b0);
                end
                17:
                begin
                    add_req(8'($urandom_range(0, 8'h1F)), 1'b0);
                end
                18:
                begin
                    add_req(8'($urandom), 1'b1);
                end
                default:
                begin
                    pick = $urandom_range(2, 4);
                    add_utf8(pick, $urandom_range(0, pick - 2));
                    add_req(8'($urandom), 1'b1);
                end
            endcase
        end

        // Hold reset, then release away from the rising edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain, then let the pipeline settle
        @(negedge clk);
        while (pending_reqs.size() != 0 || item_valid || expected_bytes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(negedge clk);

        if (n_errors == 0 && expected_bytes.size() == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/tts_pkg.sv
sv/tts_decode.sv
sv/tts_emit.sv
sv/terminal_text_sanitizer.sv
sv/tts_checker.sv
test/tb_top.sv
